>>> design/etsch_pkg.sv
// ----------------------------------------------------------------------------
// etsch_pkg
// Shared types and constants of the extended timer / two channel scheduler.
// ----------------------------------------------------------------------------
package etsch_pkg;

  localparam int TIME_BITS        = 64;
  localparam int WAIT_BITS        = 32;
  localparam int GUARD_BITS       = 8;
  localparam int LOW_COUNTER_BITS = 32;
  localparam int NUM_CHANNELS     = 2;
  localparam int MASK_BITS        = 2;
  localparam int CFG_INDEX_BITS   = 1;
  localparam int CFG_DATA_BITS    = GUARD_BITS;

  localparam logic [GUARD_BITS-1:0] GUARD_RESET = GUARD_BITS'(2);

  typedef enum logic [1:0] {
    FUNC_TICK   = 2'd0,
    FUNC_SCHED  = 2'd1,
    FUNC_CANCEL = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_PAST     = 2'd1,
    ST_DISABLED = 2'd2
  } status_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_GUARD  = 1'b0,
    CFG_CH2_EN = 1'b1
  } cfg_index_t;

  // per-channel command, already qualified by the pipeline advance
  typedef struct packed {
    logic                  do_tick;
    logic                  do_sched;
    logic                  do_cancel;
    logic                  wrap;
    logic [TIME_BITS-1:0]  target;
    logic [TIME_BITS-1:0]  time_cur;
    logic [TIME_BITS-1:0]  time_next;
    logic [GUARD_BITS-1:0] guard;
  } chan_cmd_t;

  typedef struct packed {
    logic fired;
    logic lost;
    logic past;
    logic armed;
  } chan_stat_t;

endpackage

>>> design/etsch_cmd_if.sv
// ----------------------------------------------------------------------------
// etsch_cmd_if
// Request channel: tick, schedule or cancel words.
// ----------------------------------------------------------------------------
interface etsch_cmd_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          func;
  logic                                channel;
  logic [etsch_pkg::TIME_BITS-1:0]     target_time;

  modport source (output valid, func, channel, target_time, input ready);
  modport sink   (input valid, func, channel, target_time, output ready);
endinterface

>>> design/etsch_res_if.sv
// ----------------------------------------------------------------------------
// etsch_res_if
// Result channel: one word per request.
// ----------------------------------------------------------------------------
interface etsch_res_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          status;
  logic [etsch_pkg::MASK_BITS-1:0]     fired_mask;
  logic [etsch_pkg::MASK_BITS-1:0]     lost_mask;
  logic [etsch_pkg::TIME_BITS-1:0]     current_time;

  modport source (output valid, status, fired_mask, lost_mask, current_time, input ready);
  modport sink   (input valid, status, fired_mask, lost_mask, current_time, output ready);
endinterface

>>> design/etsch_chan.sv
// ----------------------------------------------------------------------------
// etsch_chan
// One event channel: target, countdown and arm flag with their update logic.
// ----------------------------------------------------------------------------
module etsch_chan (
  input  logic                  clk,
  input  logic                  rst,
  input  etsch_pkg::chan_cmd_t  cmd,
  output etsch_pkg::chan_stat_t stat
);

  logic [etsch_pkg::TIME_BITS-1:0] target, target_next;
  logic [etsch_pkg::WAIT_BITS-1:0] remaining, remaining_next;
  logic                            armed, armed_next;

  logic [etsch_pkg::WAIT_BITS-1:0] dec;
  logic [etsch_pkg::TIME_BITS:0]   back;    // now - target, borrow on top
  logic [etsch_pkg::TIME_BITS:0]   ahead;   // target - now
  logic [etsch_pkg::TIME_BITS:0]   sdiff;   // schedule target - time
  logic                            fired, lost, past;

  always_comb begin
    target_next    = target;
    remaining_next = remaining;
    armed_next     = armed;
    fired          = 1'b0;
    lost           = 1'b0;
    past           = 1'b0;
    dec            = (remaining != '0) ? remaining - 1'b1 : remaining;

    if (cmd.do_tick && armed) begin
      remaining_next = dec;
      if (dec == '0) begin
        fired       = 1'b1;
        armed_next  = 1'b0;
        target_next = '0;
      end
    end

    back  = {1'b0, cmd.time_next} - {1'b0, target_next};
    ahead = {1'b0, target_next} - {1'b0, cmd.time_next};
    sdiff = {1'b0, cmd.target} - {1'b0, cmd.time_cur};

    // low counter wrapped: re-examine a pending target against the new time
    if (cmd.do_tick && cmd.wrap && target_next != '0) begin
      if (!back[etsch_pkg::TIME_BITS]) begin
        if (back[etsch_pkg::TIME_BITS-1:0] <=
            {{(etsch_pkg::TIME_BITS-etsch_pkg::GUARD_BITS){1'b0}}, cmd.guard}) begin
          armed_next     = 1'b1;
          remaining_next = etsch_pkg::WAIT_BITS'(1);
        end else begin
          lost = 1'b1;
        end
      end else if (ahead[etsch_pkg::TIME_BITS-1:etsch_pkg::WAIT_BITS] == '0) begin
        armed_next     = 1'b1;
        remaining_next = ahead[etsch_pkg::WAIT_BITS-1:0];
      end
    end

    if (cmd.do_sched) begin
      target_next = cmd.target;
      if (sdiff[etsch_pkg::TIME_BITS]) begin
        past = 1'b1;
      end else if (sdiff[etsch_pkg::TIME_BITS-1:etsch_pkg::WAIT_BITS] == '0) begin
        armed_next     = 1'b1;
        remaining_next = (sdiff[etsch_pkg::WAIT_BITS-1:0] == '0) ?
                         etsch_pkg::WAIT_BITS'(1) : sdiff[etsch_pkg::WAIT_BITS-1:0];
      end
    end

    if (cmd.do_cancel) begin
      target_next    = '0;
      remaining_next = '0;
      armed_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target    <= '0;
      remaining <= '0;
      armed     <= 1'b0;
    end else begin
      target    <= target_next;
      remaining <= remaining_next;
      armed     <= armed_next;
    end
  end

  assign stat.fired = fired;
  assign stat.lost  = lost;
  assign stat.past  = past;
  assign stat.armed = armed;

endmodule

>>> design/extended_timer_two_channel_scheduler_unit.sv
// ----------------------------------------------------------------------------
// extended_timer_two_channel_scheduler_unit
// 64-bit extended timer with two one-shot compare channels.
//
//   channel  dir  words carried
//   cmd      in   func, channel, target_time
//   res      out  status, fired_mask, lost_mask, current_time
//   cfg_*    in   guard_time (index 0), second_channel_enable (index 1)
//
// One word per cycle sustained while results are taken; a request passes the
// request register, then the result register, with all channel and time updates in between.
// A request waits in the request register while the result register is full
// and not taken; the request side stalls only when both are held.
// Synchronous active-high reset clears time, channels and config to defaults.
// ----------------------------------------------------------------------------
module extended_timer_two_channel_scheduler_unit (
  input  logic                                 clk,
  input  logic                                 rst,
  etsch_cmd_if.sink                            cmd,
  etsch_res_if.source                          res,
  input  logic                                 cfg_we,
  input  logic [etsch_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [etsch_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  // configuration
  logic [etsch_pkg::GUARD_BITS-1:0] guard_time;
  logic                             ch2_en;

  always_ff @(posedge clk) begin
    if (rst) begin
      guard_time <= etsch_pkg::GUARD_RESET;
      ch2_en     <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        etsch_pkg::CFG_GUARD:  guard_time <= cfg_data;
        etsch_pkg::CFG_CH2_EN: ch2_en     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // request register
  logic                            s1_valid;
  logic [1:0]                      s1_func;
  logic                            s1_channel;
  logic [etsch_pkg::TIME_BITS-1:0] s1_target;
  logic                            advance;

  assign advance   = s1_valid && (!res.valid || res.ready);
  assign cmd.ready = !rst && (!s1_valid || advance);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd.ready) begin
      s1_valid <= cmd.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s1_func    <= cmd.func;
      s1_channel <= cmd.channel;
      s1_target  <= cmd.target_time;
    end
  end

  // time base
  logic [etsch_pkg::TIME_BITS-1:0] time_count, time_count_next;
  logic                            is_tick, is_sched, is_cancel, usable, wrap;

  always_comb begin
    is_tick   = 1'b0;
    is_sched  = 1'b0;
    is_cancel = 1'b0;
    case (s1_func)
      etsch_pkg::FUNC_TICK:   is_tick   = 1'b1;
      etsch_pkg::FUNC_SCHED:  is_sched  = 1'b1;
      etsch_pkg::FUNC_CANCEL: is_cancel = 1'b1;
      default: ;
    endcase
  end

  assign usable = (int'(s1_channel) < etsch_pkg::NUM_CHANNELS) &&
                  !(s1_channel && !ch2_en);
  assign time_count_next = is_tick ? time_count + 1'b1 : time_count;
  assign wrap = (time_count_next[etsch_pkg::LOW_COUNTER_BITS-1:0] == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      time_count <= '0;
    end else if (advance) begin
      time_count <= time_count_next;
    end
  end

  // channels
  etsch_pkg::chan_cmd_t  ch_cmd  [etsch_pkg::NUM_CHANNELS];
  etsch_pkg::chan_stat_t ch_stat [etsch_pkg::NUM_CHANNELS];

  for (genvar c = 0; c < etsch_pkg::NUM_CHANNELS; c++) begin : g_chan
    logic hit;
    assign hit = advance && usable && (int'(s1_channel) == c);

    always_comb begin
      ch_cmd[c].do_tick   = advance && is_tick;
      ch_cmd[c].do_sched  = hit && is_sched;
      ch_cmd[c].do_cancel = hit && is_cancel;
      ch_cmd[c].wrap      = wrap;
      ch_cmd[c].target    = s1_target;
      ch_cmd[c].time_cur  = time_count;
      ch_cmd[c].time_next = time_count_next;
      ch_cmd[c].guard     = guard_time;
    end

    etsch_chan u_chan (
      .clk  (clk),
      .rst  (rst),
      .cmd  (ch_cmd[c]),
      .stat (ch_stat[c])
    );
  end

  // result assembly
  logic [etsch_pkg::MASK_BITS-1:0] fired, lost;
  logic                            any_past;
  logic [1:0]                      status;

  always_comb begin
    fired    = '0;
    lost     = '0;
    any_past = 1'b0;
    for (int c = 0; c < etsch_pkg::NUM_CHANNELS; c++) begin
      fired[c] = ch_stat[c].fired;
      lost[c]  = ch_stat[c].lost;
      any_past = any_past | ch_stat[c].past;
    end
    if ((is_sched || is_cancel) && !usable) begin
      status = etsch_pkg::ST_DISABLED;
    end else if (is_sched && any_past) begin
      status = etsch_pkg::ST_PAST;
    end else begin
      status = etsch_pkg::ST_OK;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else if (advance) begin
      res.valid <= 1'b1;
    end else if (res.ready) begin
      res.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res.status       <= status;
      res.fired_mask   <= fired;
      res.lost_mask    <= lost;
      res.current_time <= time_count_next;
    end
  end

  // a channel that fires has its target cleared, so it cannot be lost too
  a_fire_lost_excl: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> ((res.fired_mask & res.lost_mask) == '0))
    else $error("channel both fired and lost");

  // a tick advances the reported time by exactly one
  a_tick_step: assert property (@(posedge clk) disable iff (rst)
    (advance && is_tick) |=> (res.current_time == $past(time_count) + 1'b1))
    else $error("tick did not advance time by one");

  // only ticks report fired or lost channels
  a_mask_tick_only: assert property (@(posedge clk) disable iff (rst)
    (advance && !is_tick) |=> (res.fired_mask == '0 && res.lost_mask == '0))
    else $error("event mask set on non-tick word");

  // channel 0, once fired, is disarmed on the next cycle
  a_fire_disarm: assert property (@(posedge clk) disable iff (rst)
    (advance && ch_stat[0].fired) |=> !ch_stat[0].armed)
    else $error("primary channel still armed after firing");

endmodule

>>> test/tb_extended_timer_two_channel_scheduler_unit.sv
// ----------------------------------------------------------------------------
// tb_extended_timer_two_channel_scheduler_unit
// Self-checking bench for the extended timer and its two compare channels.
// Requests go in through a queue-fed driver. Each accepted request is run
// through a local timer model, and the result words that come back are
// compared field by field in the order of the requests. Idle and stall
// patterns on both sides change from phase to phase, and the config changes
// between phases once the block has drained.
// ----------------------------------------------------------------------------
module tb_extended_timer_two_channel_scheduler_unit;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] FUNC_UNKNOWN = 2'd3;
  localparam logic [etsch_pkg::TIME_BITS-1:0] MAX_WAIT = 64'h0000_0000_FFFF_FFFF;
  localparam int         STALL_LIMIT  = 2000;
  localparam int         PHASE_COUNT  = 8;
  localparam int         PHASE_ITEMS  = 215;
  localparam int         REPORT_LINES = 40;

  typedef struct {
    logic [1:0]                      func;
    logic                            channel;
    logic [etsch_pkg::TIME_BITS-1:0] target;
  } timer_request_t;

  typedef struct {
    etsch_pkg::status_t              status;
    logic [etsch_pkg::MASK_BITS-1:0] fired;
    logic [etsch_pkg::MASK_BITS-1:0] lost;
    logic [etsch_pkg::TIME_BITS-1:0] now_time;
  } timer_reply_t;

  logic clk;
  logic rst;
  logic                                 cfg_we;
  logic [etsch_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [etsch_pkg::CFG_DATA_BITS-1:0]  cfg_data;

  etsch_cmd_if cmd_if ();
  etsch_res_if res_if ();

  extended_timer_two_channel_scheduler_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_if.sink),
    .res       (res_if.source),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // timer model state
  logic [etsch_pkg::TIME_BITS-1:0]  model_time;
  logic [etsch_pkg::TIME_BITS-1:0]  model_target [etsch_pkg::NUM_CHANNELS];
  logic                             model_armed  [etsch_pkg::NUM_CHANNELS];
  logic [etsch_pkg::WAIT_BITS-1:0]  model_remain [etsch_pkg::NUM_CHANNELS];
  logic [etsch_pkg::GUARD_BITS-1:0] guard_setting;
  logic                             ch2_enable_setting;

  timer_request_t request_backlog [$];
  timer_reply_t   predicted_replies [$];
  logic [etsch_pkg::TIME_BITS-1:0] queued_ticks;  // time the next queued word will see
  logic offered;
  int   send_idle_pct;
  int   recv_stall_pct;
  int   rx_hold_cycles;
  int   mismatch_count;
  int   stall_cycles;

  always #5 clk = ~clk;

  function automatic void arm_channel(int c, logic [etsch_pkg::TIME_BITS-1:0] countdown);
    if (countdown == 0) countdown = 1;
    model_remain[c] = countdown[etsch_pkg::WAIT_BITS-1:0];
    model_armed[c]  = 1'b1;
  endfunction

  function automatic timer_reply_t advance_timer_model(timer_request_t req);
    timer_reply_t                    r;
    logic [etsch_pkg::TIME_BITS-1:0] t;
    logic                            usable;
    r.status   = etsch_pkg::ST_OK;
    r.fired    = '0;
    r.lost     = '0;
    usable     = (int'(req.channel) < etsch_pkg::NUM_CHANNELS) &&
                 !(req.channel == 1'b1 && !ch2_enable_setting);
    case (req.func)
      etsch_pkg::FUNC_TICK: begin
        model_time = model_time + 1;
        for (int c = 0; c < etsch_pkg::NUM_CHANNELS; c++) begin
          if (model_armed[c]) begin
            if (model_remain[c] != 0) model_remain[c] = model_remain[c] - 1;
            if (model_remain[c] == 0) begin
              r.fired[c]      = 1'b1;
              model_armed[c]  = 1'b0;
              model_target[c] = '0;
            end
          end
        end
        // low counter wrapped: re-examine deferred and missed targets
        if (model_time[etsch_pkg::LOW_COUNTER_BITS-1:0] == '0) begin
          for (int c = 0; c < etsch_pkg::NUM_CHANNELS; c++) begin
            t = model_target[c];
            if (t != 0) begin
              if (t <= model_time) begin
                if (model_time - t <= etsch_pkg::TIME_BITS'(guard_setting))
                  arm_channel(c, 1);
                else r.lost[c] = 1'b1;
              end else if (t - model_time <= MAX_WAIT) begin
                arm_channel(c, t - model_time);
              end
            end
          end
        end
      end
      etsch_pkg::FUNC_SCHED: begin
        if (!usable) begin
          r.status = etsch_pkg::ST_DISABLED;
        end else begin
          model_target[req.channel] = req.target;
          if (req.target < model_time) r.status = etsch_pkg::ST_PAST;
          else if (req.target - model_time <= MAX_WAIT)
            arm_channel(req.channel, req.target - model_time);
        end
      end
      etsch_pkg::FUNC_CANCEL: begin
        if (!usable) begin
          r.status = etsch_pkg::ST_DISABLED;
        end else begin
          model_armed[req.channel]  = 1'b0;
          model_remain[req.channel] = '0;
          model_target[req.channel] = '0;
        end
      end
      default: ;
    endcase
    r.now_time = model_time;
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [etsch_pkg::TIME_BITS-1:0] got,
                                 logic [etsch_pkg::TIME_BITS-1:0] want);
    if (mismatch_count < REPORT_LINES)
      $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic push_word(logic [1:0] fn, logic ch, logic [etsch_pkg::TIME_BITS-1:0] tgt);
    timer_request_t req;
    req.func    = fn;
    req.channel = ch;
    req.target  = tgt;
    request_backlog.push_back(req);
    if (fn == etsch_pkg::FUNC_TICK) queued_ticks = queued_ticks + 1;
  endtask

  task automatic push_ticks(int n);
    for (int i = 0; i < n; i++)
      push_word(etsch_pkg::FUNC_TICK, 1'($urandom_range(0, 1)), '0);
  endtask

  task automatic push_random_word();
    int                              pick;
    logic [1:0]                      fn;
    logic [etsch_pkg::TIME_BITS-1:0] tgt;
    pick = $urandom_range(0, 99);
    tgt  = {$urandom, $urandom};
    if (pick < 55) begin
      fn = etsch_pkg::FUNC_TICK;
    end else if (pick < 87) begin
      fn = etsch_pkg::FUNC_SCHED;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: tgt = queued_ticks + $urandom_range(0, 30);
        4:          tgt = queued_ticks;
        5, 6:       tgt = queued_ticks - $urandom_range(1, 40);
        7:          tgt = queued_ticks + MAX_WAIT - 1 + $urandom_range(0, 2);
        default: ;
      endcase
    end else if (pick < 98) begin
      fn = etsch_pkg::FUNC_CANCEL;
    end else begin
      fn = FUNC_UNKNOWN;
    end
    push_word(fn, 1'($urandom_range(0, 1)), tgt);
  endtask

  task automatic wait_drained();
    while (request_backlog.size() != 0 || offered || predicted_replies.size() != 0)
      @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_register(etsch_pkg::cfg_index_t idx,
                                logic [etsch_pkg::CFG_DATA_BITS-1:0] value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == etsch_pkg::CFG_GUARD) guard_setting = value;
    else ch2_enable_setting = value[0];
  endtask

  // request driver
  always @(negedge clk) begin : drive_requests
    timer_request_t req;
    if (!rst && !offered) begin
      if (request_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        req = request_backlog.pop_front();
        cmd_if.valid       <= 1'b1;
        cmd_if.func        <= req.func;
        cmd_if.channel     <= req.channel;
        cmd_if.target_time <= req.target;
        offered = 1'b1;
      end else begin
        cmd_if.valid <= 1'b0;
      end
    end
  end

  // result ready, with random stalls and the occasional long hold
  always @(negedge clk) begin
    res_if.ready <= !rst && rx_hold_cycles == 0 && $urandom_range(0, 99) >= recv_stall_pct;
  end

  always @(posedge clk) begin
    if (rx_hold_cycles != 0) rx_hold_cycles <= rx_hold_cycles - 1;
  end

  // predict on each accepted request, check each accepted result
  always @(posedge clk) begin : watch_ports
    timer_request_t req;
    timer_reply_t   want;
    if (!rst) begin
      if (cmd_if.valid && cmd_if.ready) begin
        req.func    = cmd_if.func;
        req.channel = cmd_if.channel;
        req.target  = cmd_if.target_time;
        predicted_replies.push_back(advance_timer_model(req));
        offered = 1'b0;
      end
      if (res_if.valid && res_if.ready) begin
        if (predicted_replies.size() == 0) begin
          report_mismatch("result word with nothing pending", res_if.current_time, '0);
        end else begin
          want = predicted_replies.pop_front();
          if (res_if.status != want.status)
            report_mismatch("status", etsch_pkg::TIME_BITS'(res_if.status),
                            etsch_pkg::TIME_BITS'(want.status));
          if (res_if.fired_mask != want.fired)
            report_mismatch("fired_mask", etsch_pkg::TIME_BITS'(res_if.fired_mask),
                            etsch_pkg::TIME_BITS'(want.fired));
          if (res_if.lost_mask != want.lost)
            report_mismatch("lost_mask", etsch_pkg::TIME_BITS'(res_if.lost_mask),
                            etsch_pkg::TIME_BITS'(want.lost));
          if (res_if.current_time != want.now_time)
            report_mismatch("current_time", res_if.current_time, want.now_time);
        end
      end
    end
  end

  // watchdog: too long without any word moving
  always @(posedge clk) begin
    if (rst || (cmd_if.valid && cmd_if.ready) || (res_if.valid && res_if.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    clk                = 1'b0;
    rst                = 1'b1;
    cfg_we             = 1'b0;
    cfg_index          = etsch_pkg::CFG_GUARD;
    cfg_data           = '0;
    cmd_if.valid       = 1'b0;
    cmd_if.func        = etsch_pkg::FUNC_TICK;
    cmd_if.channel     = 1'b0;
    cmd_if.target_time = '0;
    res_if.ready       = 1'b0;
    offered            = 1'b0;
    send_idle_pct      = 0;
    recv_stall_pct     = 0;
    rx_hold_cycles     = 0;
    mismatch_count     = 0;
    stall_cycles       = 0;
    queued_ticks       = '0;
    model_time         = '0;
    for (int c = 0; c < etsch_pkg::NUM_CHANNELS; c++) begin
      model_target[c] = '0;
      model_armed[c]  = 1'b0;
      model_remain[c] = '0;
    end
    guard_setting      = etsch_pkg::GUARD_RESET;
    ch2_enable_setting = 1'b1;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: schedule at now, both channels, deferral, boundary, cancel
    push_word(etsch_pkg::FUNC_SCHED, 1'b0, '0);
    push_ticks(1);
    push_word(etsch_pkg::FUNC_SCHED, 1'b1, queued_ticks + 3);
    push_word(etsch_pkg::FUNC_SCHED, 1'b0, queued_ticks + 2);
    push_ticks(3);
    push_word(etsch_pkg::FUNC_SCHED, 1'b0, '1);
    push_word(etsch_pkg::FUNC_SCHED, 1'b1, queued_ticks + MAX_WAIT);
    push_word(etsch_pkg::FUNC_SCHED, 1'b1, queued_ticks + MAX_WAIT + 1);  // stays armed
    push_word(etsch_pkg::FUNC_TICK, 1'b1, '1);
    push_word(etsch_pkg::FUNC_CANCEL, 1'b0, '0);
    push_word(etsch_pkg::FUNC_CANCEL, 1'b1, '1);
    push_word(etsch_pkg::FUNC_SCHED, 1'b0, '0);
    push_word(etsch_pkg::FUNC_SCHED, 1'b1, queued_ticks - 1);
    push_word(FUNC_UNKNOWN, 1'b1, '1);
    push_word(etsch_pkg::FUNC_SCHED, 1'b0, queued_ticks + 1);
    push_word(etsch_pkg::FUNC_SCHED, 1'b1, queued_ticks + 1);
    push_ticks(1);
    push_word(etsch_pkg::FUNC_CANCEL, 1'b0, '0);
    push_word(etsch_pkg::FUNC_SCHED, 1'b1, queued_ticks + 4);
    wait_drained();

    // channel 1 disabled while its countdown runs
    write_register(etsch_pkg::CFG_CH2_EN, '0);
    write_register(etsch_pkg::CFG_GUARD, 8'd255);
    push_word(etsch_pkg::FUNC_SCHED, 1'b1, queued_ticks + 1);
    push_word(etsch_pkg::FUNC_CANCEL, 1'b1, '0);
    push_ticks(4);
    wait_drained();

    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p)
        0:       write_register(etsch_pkg::CFG_GUARD, 8'd255);
        1:       write_register(etsch_pkg::CFG_GUARD, 8'd0);
        2:       write_register(etsch_pkg::CFG_GUARD, etsch_pkg::GUARD_RESET);
        default: write_register(etsch_pkg::CFG_GUARD,
                                etsch_pkg::CFG_DATA_BITS'($urandom_range(0, 255)));
      endcase
      write_register(etsch_pkg::CFG_CH2_EN, etsch_pkg::CFG_DATA_BITS'(p % 3 != 2));
      case (p % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 62; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 62; end
        default: begin send_idle_pct = 37; recv_stall_pct = 37; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) push_random_word();
      if (p == 0) begin
        // hold results back while requests keep coming so the input stalls
        @(negedge clk);
        rx_hold_cycles = 150;
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
